// ----- rtl/dls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Door lock sequencer package
// Beat types, configuration register indexes, lamp bit positions and
// configuration reset values shared by the door lock sequencer.
// ----------------------------------------------------------------------------
package dls_pkg;

    // Input beat: active-low button levels and the timer tick flag
    typedef struct packed {
        logic unlock_button;
        logic handle_btn;
        logic tick;
    } in_t;

    // Result beat: lamp levels and door status after one pass
    typedef struct packed {
        logic vehicle_lamp;
        logic hazard_lamp;
        logic ambient_lamp;
        logic locked_status;
        logic open_status;
    } out_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_UNLOCK_FLASH  = 3'd0,
        CFG_UNLOCK_SETTLE = 3'd1,
        CFG_AUTO_RELOCK   = 3'd2,
        CFG_CLOSE_DELAY   = 3'd3,
        CFG_LOCK_BLINK    = 3'd4,
        CFG_TOGGLE_COUNT  = 3'd5
    } cfg_idx_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned COUNT_W    = 4;

    // Lamp bit positions within the lamp level vector
    localparam int unsigned LAMP_VEHICLE = 0;
    localparam int unsigned LAMP_HAZARD  = 1;
    localparam int unsigned LAMP_AMBIENT = 2;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] RST_UNLOCK_FLASH  = 16'd500;
    localparam logic [CFG_DATA_W-1:0] RST_UNLOCK_SETTLE = 16'd1500;
    localparam logic [CFG_DATA_W-1:0] RST_AUTO_RELOCK   = 16'd10000;
    localparam logic [CFG_DATA_W-1:0] RST_CLOSE_DELAY   = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] RST_LOCK_BLINK    = 16'd500;
    localparam logic [COUNT_W-1:0]    RST_TOGGLE_COUNT  = 4'd3;

endpackage

// ----- rtl/door_lock_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Door lock sequencer
// Door lock and anti-theft relock controller: one polling pass per beat.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock while s_ready is high and returns
// one result beat for each, in the cycle after acceptance, in order. The whole
// pass (tick applied to the one-shot timer, locked branch, then unlocked
// branch) is combinational flag logic and a single TIMER_WIDTH down counter,
// and the state and result register load together on acceptance. s_ready is
// high whenever the result register is empty or being taken in the same cycle,
// so with m_ready held high a new beat enters every cycle. Configuration
// writes are taken at any time through cfg_valid/cfg_ready and act from the
// next beat on; the tick values are cut or zero-extended to TIMER_WIDTH bits.
module door_lock_sequencer #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input beats
    input  logic                             s_valid,
    output logic                             s_ready,
    input  dls_pkg::in_t                     s_data,
    // result beats
    output logic                             m_valid,
    input  logic                             m_ready,
    output dls_pkg::out_t                    m_data,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dls_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int unsigned CW = dls_pkg::COUNT_W;

    // configuration registers
    logic [dls_pkg::CFG_DATA_W-1:0] flash_ticks_reg;
    logic [dls_pkg::CFG_DATA_W-1:0] settle_ticks_reg;
    logic [dls_pkg::CFG_DATA_W-1:0] relock_ticks_reg;
    logic [dls_pkg::CFG_DATA_W-1:0] close_ticks_reg;
    logic [dls_pkg::CFG_DATA_W-1:0] blink_ticks_reg;
    logic [CW-1:0]                  toggle_count_reg;

    // pass state
    logic                   locked_reg,        locked_next;
    logic                   door_open_reg,     door_open_next;
    logic                   press_latch_reg,   press_latch_next;
    logic                   blink_restart_reg, blink_restart_next;
    logic                   hazard_phase_reg,  hazard_phase_next;
    logic [CW-1:0]          blink_count_reg,   blink_count_next;
    logic                   relock_en_reg,     relock_en_next;
    logic                   relocking_reg,     relocking_next;
    logic                   relock_arm_reg,    relock_arm_next;
    logic [TIMER_WIDTH-1:0] timer_rem_reg,     timer_rem_next;
    logic                   timer_exp_reg,     timer_exp_next;
    logic [2:0]             lamps_reg,         lamps_next;

    logic                   m_valid_reg;
    dls_pkg::out_t          m_data_reg;

    logic                   accept;
    logic                   unlock_pressed;
    logic                   handle_pressed;

    assign cfg_ready      = 1'b1;
    assign s_ready        = !m_valid_reg || m_ready;
    assign accept         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;
    assign unlock_pressed = !s_data.unlock_button;
    assign handle_pressed = !s_data.handle_btn;

    // Take configuration writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_ticks_reg  <= dls_pkg::RST_UNLOCK_FLASH;
            settle_ticks_reg <= dls_pkg::RST_UNLOCK_SETTLE;
            relock_ticks_reg <= dls_pkg::RST_AUTO_RELOCK;
            close_ticks_reg  <= dls_pkg::RST_CLOSE_DELAY;
            blink_ticks_reg  <= dls_pkg::RST_LOCK_BLINK;
            toggle_count_reg <= dls_pkg::RST_TOGGLE_COUNT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dls_pkg::CFG_UNLOCK_FLASH:  flash_ticks_reg  <= cfg_data;
                dls_pkg::CFG_UNLOCK_SETTLE: settle_ticks_reg <= cfg_data;
                dls_pkg::CFG_AUTO_RELOCK:   relock_ticks_reg <= cfg_data;
                dls_pkg::CFG_CLOSE_DELAY:   close_ticks_reg  <= cfg_data;
                dls_pkg::CFG_LOCK_BLINK:    blink_ticks_reg  <= cfg_data;
                dls_pkg::CFG_TOGGLE_COUNT:  toggle_count_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // One polling pass: tick the timer, then the locked and unlocked branches
    always_comb begin
        locked_next        = locked_reg;
        door_open_next     = door_open_reg;
        press_latch_next   = press_latch_reg;
        blink_restart_next = blink_restart_reg;
        hazard_phase_next  = hazard_phase_reg;
        blink_count_next   = blink_count_reg;
        relock_en_next     = relock_en_reg;
        relocking_next     = relocking_reg;
        relock_arm_next    = relock_arm_reg;
        timer_rem_next     = timer_rem_reg;
        timer_exp_next     = timer_exp_reg;
        lamps_next         = lamps_reg;

        // apply the tick to the one-shot timer
        if (s_data.tick && (timer_rem_next != '0)) begin
            timer_rem_next = timer_rem_next - TIMER_WIDTH'(1);
            if (timer_rem_next == '0) begin
                timer_exp_next = 1'b1;
            end
        end

        // locked: handle press starts the unlock flash and settle
        if (locked_next) begin
            if (handle_pressed && !press_latch_next) begin
                timer_rem_next    = TIMER_WIDTH'(flash_ticks_reg);
                timer_exp_next    = (TIMER_WIDTH'(flash_ticks_reg) == '0);
                lamps_next        = 3'b111;
                hazard_phase_next = 1'b1;
                press_latch_next  = 1'b1;
            end
            if (press_latch_next) begin
                if (hazard_phase_next) begin
                    if (timer_exp_next) begin
                        hazard_phase_next                = 1'b0;
                        lamps_next[dls_pkg::LAMP_HAZARD] = 1'b0;
                        timer_rem_next = TIMER_WIDTH'(settle_ticks_reg);
                        timer_exp_next = (TIMER_WIDTH'(settle_ticks_reg) == '0);
                    end
                end else if (timer_exp_next) begin
                    lamps_next[dls_pkg::LAMP_AMBIENT] = 1'b0;
                    locked_next       = 1'b0;
                    press_latch_next  = 1'b0;
                    hazard_phase_next = 1'b1;
                end
            end
        end

        // unlocked: open, close, or relock (falls through from an unlock)
        if (!locked_next) begin
            if (!door_open_next) begin
                if (relock_arm_next) begin
                    timer_rem_next  = TIMER_WIDTH'(relock_ticks_reg);
                    timer_exp_next  = (TIMER_WIDTH'(relock_ticks_reg) == '0);
                    relock_arm_next = 1'b0;
                end
                if (unlock_pressed) begin
                    door_open_next   = 1'b1;
                    lamps_next       = 3'b100;
                    relock_arm_next  = 1'b1;
                    press_latch_next = 1'b1;
                end else if (handle_pressed) begin
                    if (!press_latch_next) begin
                        lamps_next         = 3'b010;
                        hazard_phase_next  = 1'b1;
                        press_latch_next   = 1'b1;
                        relocking_next     = 1'b1;
                        blink_restart_next = 1'b1;
                    end
                end else if (relock_en_next) begin
                    press_latch_next = 1'b0;
                    if (timer_exp_next) begin
                        lamps_next         = 3'b010;
                        blink_restart_next = 1'b1;
                        relocking_next     = 1'b1;
                        hazard_phase_next  = 1'b1;
                        relock_en_next     = 1'b0;
                    end
                end
                // blink sequence, then lock
                if (relocking_next) begin
                    if (blink_count_next < toggle_count_reg) begin
                        if (blink_restart_next) begin
                            timer_rem_next = TIMER_WIDTH'(blink_ticks_reg);
                            timer_exp_next = (TIMER_WIDTH'(blink_ticks_reg) == '0);
                            blink_restart_next = 1'b0;
                        end
                        if (timer_exp_next) begin
                            blink_restart_next = 1'b1;
                            blink_count_next   = blink_count_next + CW'(1);
                            hazard_phase_next  = !hazard_phase_next;
                            lamps_next[dls_pkg::LAMP_HAZARD] = hazard_phase_next;
                        end
                    end else begin
                        blink_count_next = '0;
                        relocking_next   = 1'b0;
                        relock_en_next   = 1'b1;
                        locked_next      = 1'b1;
                        relock_arm_next  = 1'b1;
                    end
                end
            end else begin
                if (unlock_pressed) begin
                    if (!press_latch_next) begin
                        lamps_next       = 3'b100;
                        timer_rem_next   = TIMER_WIDTH'(close_ticks_reg);
                        timer_exp_next   = (TIMER_WIDTH'(close_ticks_reg) == '0);
                        press_latch_next = 1'b1;
                        if (timer_exp_next) begin
                            lamps_next[dls_pkg::LAMP_AMBIENT] = 1'b0;
                            press_latch_next = 1'b0;
                            door_open_next   = 1'b0;
                        end
                    end
                end else begin
                    press_latch_next = 1'b0;
                    if (timer_exp_next) begin
                        lamps_next[dls_pkg::LAMP_AMBIENT] = 1'b0;
                        press_latch_next = 1'b0;
                        door_open_next   = 1'b0;
                    end
                end
            end
        end
    end

    // Advance the state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locked_reg        <= 1'b1;
            door_open_reg     <= 1'b0;
            press_latch_reg   <= 1'b0;
            blink_restart_reg <= 1'b1;
            hazard_phase_reg  <= 1'b1;
            blink_count_reg   <= '0;
            relock_en_reg     <= 1'b1;
            relocking_reg     <= 1'b0;
            relock_arm_reg    <= 1'b1;
            timer_rem_reg     <= '0;
            timer_exp_reg     <= 1'b0;
            lamps_reg         <= '0;
        end else if (accept) begin
            locked_reg        <= locked_next;
            door_open_reg     <= door_open_next;
            press_latch_reg   <= press_latch_next;
            blink_restart_reg <= blink_restart_next;
            hazard_phase_reg  <= hazard_phase_next;
            blink_count_reg   <= blink_count_next;
            relock_en_reg     <= relock_en_next;
            relocking_reg     <= relocking_next;
            relock_arm_reg    <= relock_arm_next;
            timer_rem_reg     <= timer_rem_next;
            timer_exp_reg     <= timer_exp_next;
            lamps_reg         <= lamps_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.vehicle_lamp  <= lamps_next[dls_pkg::LAMP_VEHICLE];
            m_data_reg.hazard_lamp   <= lamps_next[dls_pkg::LAMP_HAZARD];
            m_data_reg.ambient_lamp  <= lamps_next[dls_pkg::LAMP_AMBIENT];
            m_data_reg.locked_status <= locked_next;
            m_data_reg.open_status   <= door_open_next;
        end
    end

    // A waiting result beat stays put until taken
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("waiting result beat changed or dropped");

    // The relock blink sequence only runs while unlocked
    a_relock_unlocked: assert property (@(posedge aclk) disable iff (!aresetn)
        relocking_reg |-> !locked_reg)
        else $error("relock sequence active while locked");

    // An expired timer has nothing left to count
    a_timer_expired_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        timer_exp_reg |-> (timer_rem_reg == '0))
        else $error("timer expired with count remaining");

    // Every accepted beat leaves a result waiting
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted beat produced no result");

    // The door state moves only on an accepted beat
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> ($stable(locked_reg) && $stable(door_open_reg)
                     && $stable(timer_rem_reg)))
        else $error("state changed without an accepted beat");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Door lock sequencer testbench
// Drives polling beats and register writes into the sequencer and keeps its
// own copy of the lock, blink and timer state to predict every result beat.
// Directed passes cover reset, odd register values and a full lock cycle.
// Random held-button traffic runs under changing settings and idling. A last
// pass loads every timer with its largest value.
// ----------------------------------------------------------------------------
module testbench;

    // Indexes past the last register: writes there must be dropped
    localparam logic [dls_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [dls_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam logic [dls_pkg::CFG_DATA_W-1:0] TICKS_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [dls_pkg::CFG_IDX_W-1:0]  idx;
        logic [dls_pkg::CFG_DATA_W-1:0] val;
    } reg_write_t;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    dls_pkg::in_t                   s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    dls_pkg::out_t                  m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dls_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dls_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int mismatch_count = 0;

    dls_pkg::out_t lamp_status_q[$];
    reg_write_t    reg_writes_q[$];

    // Predicted register contents
    logic [dls_pkg::CFG_DATA_W-1:0] flash_ticks;
    logic [dls_pkg::CFG_DATA_W-1:0] settle_ticks;
    logic [dls_pkg::CFG_DATA_W-1:0] relock_ticks;
    logic [dls_pkg::CFG_DATA_W-1:0] close_ticks;
    logic [dls_pkg::CFG_DATA_W-1:0] blink_ticks;
    logic [dls_pkg::COUNT_W-1:0]    toggle_count;

    // Predicted controller state
    logic                        is_locked;
    logic                        door_open;
    logic                        press_latch;
    logic                        blink_restart;
    logic                        hazard_phase;
    logic [dls_pkg::COUNT_W-1:0] blink_count;
    logic                        relock_enable;
    logic                        relocking;
    logic                        relock_arm;
    logic [15:0]                 timer_left;
    logic                        timer_done;
    logic [2:0]                  lamps;

    door_lock_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Load the one-shot timer; a zero load counts as expired at once
    function automatic void load_timer(input logic [15:0] ticks);
        timer_left = ticks;
        timer_done = (ticks == '0);
    endfunction

    // Drop the ambient lamp and close the door once the timer has run out
    function automatic void finish_close();
        if (timer_done) begin
            lamps[dls_pkg::LAMP_AMBIENT] = 1'b0;
            press_latch = 1'b0;
            door_open   = 1'b0;
        end
    endfunction

    // Run one polling pass on the predicted state and queue its result
    function automatic void predict_pass(input dls_pkg::in_t beat);
        logic unlock_down;
        logic handle_down;
        dls_pkg::out_t res;
        unlock_down = !beat.unlock_button;
        handle_down = !beat.handle_btn;

        // apply the tick before any decision
        if (beat.tick && timer_left != '0) begin
            timer_left = timer_left - 16'd1;
            if (timer_left == '0)
                timer_done = 1'b1;
        end

        // locked: flash, settle, then fall through as unlocked
        if (is_locked) begin
            if (handle_down && !press_latch) begin
                load_timer(flash_ticks);
                lamps = '1;
                hazard_phase = 1'b1;
                press_latch  = 1'b1;
            end
            if (press_latch) begin
                if (hazard_phase) begin
                    if (timer_done) begin
                        hazard_phase = 1'b0;
                        lamps[dls_pkg::LAMP_HAZARD] = 1'b0;
                        load_timer(settle_ticks);
                    end
                end else if (timer_done) begin
                    lamps[dls_pkg::LAMP_AMBIENT] = 1'b0;
                    is_locked    = 1'b0;
                    press_latch  = 1'b0;
                    hazard_phase = 1'b1;
                end
            end
        end

        if (!is_locked) begin
            if (!door_open) begin
                if (relock_arm) begin
                    load_timer(relock_ticks);
                    relock_arm = 1'b0;
                end
                if (unlock_down) begin
                    door_open = 1'b1;
                    lamps = '0;
                    lamps[dls_pkg::LAMP_AMBIENT] = 1'b1;
                    relock_arm  = 1'b1;
                    press_latch = 1'b1;
                end else if (handle_down) begin
                    if (!press_latch) begin
                        lamps = '0;
                        lamps[dls_pkg::LAMP_HAZARD] = 1'b1;
                        hazard_phase  = 1'b1;
                        press_latch   = 1'b1;
                        relocking     = 1'b1;
                        blink_restart = 1'b1;
                    end
                end else if (relock_enable) begin
                    press_latch = 1'b0;
                    if (timer_done) begin
                        lamps = '0;
                        lamps[dls_pkg::LAMP_HAZARD] = 1'b1;
                        blink_restart = 1'b1;
                        relocking     = 1'b1;
                        hazard_phase  = 1'b1;
                        relock_enable = 1'b0;
                    end
                end

                // blink the hazard lamp, then count as locked
                if (relocking) begin
                    if (blink_count < toggle_count) begin
                        if (blink_restart) begin
                            load_timer(blink_ticks);
                            blink_restart = 1'b0;
                        end
                        if (timer_done) begin
                            blink_restart = 1'b1;
                            blink_count   = blink_count + 4'd1;
                            hazard_phase  = !hazard_phase;
                            lamps[dls_pkg::LAMP_HAZARD] = hazard_phase;
                        end
                    end else begin
                        blink_count   = '0;
                        relocking     = 1'b0;
                        relock_enable = 1'b1;
                        is_locked     = 1'b1;
                        relock_arm    = 1'b1;
                    end
                end
            end else begin
                if (unlock_down) begin
                    if (!press_latch) begin
                        lamps = '0;
                        lamps[dls_pkg::LAMP_AMBIENT] = 1'b1;
                        load_timer(close_ticks);
                        press_latch = 1'b1;
                        finish_close();
                    end
                end else begin
                    press_latch = 1'b0;
                    finish_close();
                end
            end
        end

        res.vehicle_lamp  = lamps[dls_pkg::LAMP_VEHICLE];
        res.hazard_lamp   = lamps[dls_pkg::LAMP_HAZARD];
        res.ambient_lamp  = lamps[dls_pkg::LAMP_AMBIENT];
        res.locked_status = is_locked;
        res.open_status   = door_open;
        lamp_status_q.push_back(res);
    endfunction

    // Hold the beat until taken, after an optional random gap
    task automatic send_beat(input dls_pkg::in_t beat);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        predict_pass(beat);
    endtask

    // Send one pass given the buttons as pressed (active high) and the tick
    task automatic poll(input logic unlock_down, input logic handle_down,
                        input logic tick_in);
        dls_pkg::in_t beat;
        beat.unlock_button = !unlock_down;
        beat.handle_btn    = !handle_down;
        beat.tick          = tick_in;
        send_beat(beat);
    endtask

    // Stop sending and wait for every predicted beat to come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (lamp_status_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic stage_write(input logic [dls_pkg::CFG_IDX_W-1:0] idx,
                               input logic [dls_pkg::CFG_DATA_W-1:0] val);
        reg_writes_q.push_back('{idx: idx, val: val});
    endtask

    // Write every staged register once the block is idle
    task automatic write_registers();
        drain_results();
        foreach (reg_writes_q[k]) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_writes_q[k].idx;
            cfg_data  <= reg_writes_q[k].val;
            do @(posedge aclk); while (!cfg_ready);
            case (reg_writes_q[k].idx)
                dls_pkg::CFG_UNLOCK_FLASH:  flash_ticks  = reg_writes_q[k].val;
                dls_pkg::CFG_UNLOCK_SETTLE: settle_ticks = reg_writes_q[k].val;
                dls_pkg::CFG_AUTO_RELOCK:   relock_ticks = reg_writes_q[k].val;
                dls_pkg::CFG_CLOSE_DELAY:   close_ticks  = reg_writes_q[k].val;
                dls_pkg::CFG_LOCK_BLINK:    blink_ticks  = reg_writes_q[k].val;
                dls_pkg::CFG_TOGGLE_COUNT:
                    toggle_count = reg_writes_q[k].val[dls_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        reg_writes_q.delete();
    endtask

    // Let the controller run with buttons released until locked and unlatched
    task automatic steer_to_rest();
        while (!(is_locked && !press_latch))
            poll(1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_reset_values();
        flash_ticks   = dls_pkg::RST_UNLOCK_FLASH;
        settle_ticks  = dls_pkg::RST_UNLOCK_SETTLE;
        relock_ticks  = dls_pkg::RST_AUTO_RELOCK;
        close_ticks   = dls_pkg::RST_CLOSE_DELAY;
        blink_ticks   = dls_pkg::RST_LOCK_BLINK;
        toggle_count  = dls_pkg::RST_TOGGLE_COUNT;
        is_locked     = 1'b1;
        door_open     = 1'b0;
        press_latch   = 1'b0;
        blink_restart = 1'b1;
        hazard_phase  = 1'b1;
        blink_count   = '0;
        relock_enable = 1'b1;
        relocking     = 1'b0;
        relock_arm    = 1'b1;
        timer_left    = '0;
        timer_done    = 1'b0;
        lamps         = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // idle timer: a tick at zero must not expire it
        poll(1'b0, 1'b0, 1'b0);
        poll(1'b0, 1'b0, 1'b1);
    endtask

    // Dropped writes, masked count, zero close delay, zero toggles, stale expiry
    task automatic test_special_cases();
        stage_write(CFG_SPARE_6, TICKS_MAX);
        stage_write(CFG_SPARE_7, TICKS_MAX);
        stage_write(dls_pkg::CFG_UNLOCK_FLASH, 16'd1);
        stage_write(dls_pkg::CFG_UNLOCK_SETTLE, 16'd1);
        stage_write(dls_pkg::CFG_AUTO_RELOCK, 16'd4);
        stage_write(dls_pkg::CFG_CLOSE_DELAY, 16'd0);
        stage_write(dls_pkg::CFG_LOCK_BLINK, 16'd1);
        stage_write(dls_pkg::CFG_TOGGLE_COUNT, 16'hFFF0);
        write_registers();
        poll(1'b0, 1'b1, 1'b0);
        while (is_locked)
            poll(1'b0, 1'b0, 1'b1);
        poll(1'b1, 1'b0, 1'b0);
        poll(1'b0, 1'b0, 1'b0);
        poll(1'b1, 1'b0, 1'b0);
        poll(1'b0, 1'b1, 1'b0);
        poll(1'b0, 1'b0, 1'b0);
        poll(1'b0, 1'b0, 1'b1);
    endtask

    // Unlock, open, close, auto relock and blink with short timers
    task automatic test_lock_cycle();
        steer_to_rest();
        stage_write(dls_pkg::CFG_UNLOCK_FLASH, 16'd2);
        stage_write(dls_pkg::CFG_UNLOCK_SETTLE, 16'd1);
        stage_write(dls_pkg::CFG_AUTO_RELOCK, 16'd3);
        stage_write(dls_pkg::CFG_CLOSE_DELAY, 16'd2);
        stage_write(dls_pkg::CFG_LOCK_BLINK, 16'd1);
        stage_write(dls_pkg::CFG_TOGGLE_COUNT, 16'd2);
        write_registers();
        poll(1'b0, 1'b1, 1'b0);
        poll(1'b0, 1'b1, 1'b1);
        poll(1'b1, 1'b1, 1'b1);
        poll(1'b0, 1'b0, 1'b1);
        poll(1'b0, 1'b0, 1'b1);
        poll(1'b0, 1'b0, 1'b1);
        poll(1'b0, 1'b0, 1'b1);
        poll(1'b0, 1'b1, 1'b1);
        poll(1'b0, 1'b0, 1'b1);
        poll(1'b0, 1'b0, 1'b1);
        poll(1'b1, 1'b0, 1'b1);
        poll(1'b1, 1'b0, 1'b1);
        poll(1'b0, 1'b0, 1'b0);
        poll(1'b1, 1'b0, 1'b1);
        poll(1'b0, 1'b0, 1'b1);
        poll(1'b0, 1'b0, 1'b1);
    endtask

    // Held-button traffic under fresh short settings for each chunk
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        logic unlock_held;
        logic handle_held;
        logic [dls_pkg::CFG_DATA_W-1:0] count_val;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        unlock_held = 1'b0;
        handle_held = 1'b0;
        for (int chunk = 0; chunk < 4; chunk++) begin
            // pick short timers so every sequence completes within a chunk
            case (chunk)
                1:       count_val = 16'd15;
                2:       count_val = 16'd1;
                default: count_val = 16'($urandom_range(1, 15));
            endcase
            stage_write(dls_pkg::CFG_UNLOCK_FLASH,
                        ($urandom_range(7) == 0) ? 16'd1 : 16'($urandom_range(2, 6)));
            stage_write(dls_pkg::CFG_UNLOCK_SETTLE,
                        ($urandom_range(7) == 0) ? 16'd1 : 16'($urandom_range(2, 6)));
            stage_write(dls_pkg::CFG_AUTO_RELOCK,
                        ($urandom_range(7) == 0) ? 16'd1 : 16'($urandom_range(2, 8)));
            stage_write(dls_pkg::CFG_CLOSE_DELAY,
                        ($urandom_range(7) == 0) ? 16'd1 : 16'($urandom_range(2, 6)));
            stage_write(dls_pkg::CFG_LOCK_BLINK, 16'($urandom_range(1, 3)));
            stage_write(dls_pkg::CFG_TOGGLE_COUNT, count_val);
            write_registers();
            for (int n = 0; n < 135; n++) begin
                // mostly held presses, some noise beats
                if ($urandom_range(99) < 10) begin
                    poll(1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
                end else begin
                    if ($urandom_range(99) < (unlock_held ? 35 : 12))
                        unlock_held = !unlock_held;
                    if ($urandom_range(99) < (handle_held ? 35 : 12))
                        handle_held = !handle_held;
                    poll(unlock_held, handle_held, $urandom_range(99) < 60);
                end
            end
        end
    endtask

    // Every timer loaded with its largest value; no early expiry may show
    task automatic test_longest_timers();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        steer_to_rest();
        stage_write(dls_pkg::CFG_UNLOCK_FLASH, TICKS_MAX);
        stage_write(dls_pkg::CFG_UNLOCK_SETTLE, TICKS_MAX);
        stage_write(dls_pkg::CFG_AUTO_RELOCK, TICKS_MAX);
        stage_write(dls_pkg::CFG_CLOSE_DELAY, TICKS_MAX);
        stage_write(dls_pkg::CFG_LOCK_BLINK, TICKS_MAX);
        stage_write(dls_pkg::CFG_TOGGLE_COUNT, 16'd1);
        write_registers();
        poll(1'b0, 1'b1, 1'b0);
        repeat (16)
            poll(1'b0, 1'b0, 1'b1);
    endtask

    task automatic note_mismatch(input string what, input dls_pkg::out_t want,
                                 input dls_pkg::out_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected %b got %b (vehicle hazard ambient locked open)",
                     $time, what, want, got);
    endtask

    // Randomise result back-pressure every cycle
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each result beat with the oldest prediction
    always @(posedge aclk) begin : check_results
        dls_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (lamp_status_q.size() == 0) begin
                note_mismatch("unexpected beat", '0, m_data);
            end else begin
                want = lamp_status_q.pop_front();
                if (m_data !== want)
                    note_mismatch("wrong result", want, m_data);
            end
        end
    end

    initial begin
        send_idle_pct = 37;
        recv_idle_pct = 69;
        test_reset_values();
        test_special_cases();
        test_lock_cycle();
        test_random_traffic(37, 69);
        test_random_traffic(69, 37);
        test_random_traffic(0, 0);
        test_longest_timers();
        drain_results();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dls_pkg.sv
rtl/door_lock_sequencer.sv
test/testbench.sv
